[rtl/msi_pkg.sv]
// Shared types and codes for the multibyte sequence indexer.
package msi_pkg;

  // Operation codes carried by each input transaction.
  typedef enum logic [1:0] {
    OP_MAP    = 2'd0,
    OP_ENTRY  = 2'd1,
    OP_BASE   = 2'd2,
    OP_COUNT  = 2'd3
  } op_t;

  // Entry actions.
  typedef enum logic [1:0] {
    ACT_CONTINUE   = 2'd0,
    ACT_FINAL      = 2'd1,
    ACT_FINAL_PAIR = 2'd2,
    ACT_BAD        = 2'd3
  } act_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_MATCH   = 2'd1,
    ST_DISALLOWED = 2'd2,
    ST_INCOMPLETE = 2'd3
  } status_t;

  // Back end sequencer states.
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_BASE,
    BK_READ,
    BK_CHECK,
    BK_MUL,
    BK_SUM,
    BK_EMIT
  } bk_state_t;

endpackage

[rtl/msi_front.sv]
// Front end: accepts transactions and queues them for the back end.
module msi_front
  import msi_pkg::*;
#(
  parameter int W = 106,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  output logic         full,
  input  logic [W-1:0] din,
  output logic         q_valid,
  input  logic         q_take,
  output logic [W-1:0] q_data
);

  localparam int AW = $clog2(DEPTH);

  logic [W-1:0] mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == (AW+1)'(DEPTH));
  assign q_valid = (count != '0);
  assign do_push = push && !full;
  assign do_pop  = q_take && q_valid;
  assign q_data  = mem[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

endmodule

[rtl/msi_back.sv]
// Back end: table writes and the per-byte range search and multiply-add.
module msi_back
  import msi_pkg::*;
#(
  parameter int NUM_STATES = 16,
  parameter int ENTRIES_PER_STATE = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  output logic        q_take,
  input  logic [1:0]  op,
  input  logic [3:0]  table_state,
  input  logic [3:0]  slot,
  input  logic [7:0]  range_low,
  input  logic [7:0]  range_high,
  input  logic [3:0]  nxt_state,
  input  logic [1:0]  action,
  input  logic [31:0] entry_value,
  input  logic [31:0] entry_mul,
  input  logic [7:0]  byte_value,
  input  logic        last_byte,
  input  logic        start_state_one,
  output logic        res_valid,
  input  logic        res_take,
  output logic [31:0] mapped_index,
  output logic [1:0]  status
);

  localparam int SW  = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
  localparam int CW  = $clog2(ENTRIES_PER_STATE + 1);
  localparam int TOT = NUM_STATES * ENTRIES_PER_STATE;
  localparam int IW  = $clog2(TOT);

  // Entry memories and state tables.
  logic [21:0] bounds_mem [TOT];
  logic [31:0] offs_mem   [TOT];
  logic [31:0] mul_mem    [TOT];
  logic [31:0] base_mem   [NUM_STATES];
  logic [CW-1:0] counts   [NUM_STATES];

  bk_state_t st, st_next;
  logic [3:0]  cur_state;
  logic [31:0] sum;
  logic        in_seq;
  logic        done;
  logic [1:0]  pend;
  logic [CW-1:0] k;
  logic [21:0] rd_bounds;
  logic [31:0] rd_offs;
  logic [31:0] rd_mul;
  logic [31:0] rd_base;
  logic [31:0] product;
  logic        out_full;
  logic [31:0] out_idx;
  logic [1:0]  out_st;

  logic        st_ok;
  logic        slot_ok;
  logic [IW-1:0] wr_idx;
  logic [IW-1:0] rd_idx;
  logic [SW-1:0] start_sel;
  logic [CW-1:0] cur_count;
  logic [7:0]  lo, hi;
  logic        hit;
  logic [7:0]  byte_off;

  assign st_ok    = ({4'd0, table_state} < 8'(NUM_STATES));
  assign slot_ok  = ({4'd0, slot} < 8'(ENTRIES_PER_STATE));
  assign wr_idx   = IW'(table_state) * IW'(ENTRIES_PER_STATE) + IW'(slot);
  assign rd_idx   = IW'(cur_state) * IW'(ENTRIES_PER_STATE) + IW'(k);
  assign start_sel = (start_state_one && !last_byte) ? SW'(1) : SW'(0);
  assign cur_count = ({4'd0, cur_state} < 8'(NUM_STATES)) ? counts[SW'(cur_state)] : '0;
  assign lo       = rd_bounds[7:0];
  assign hi       = rd_bounds[15:8];
  assign hit      = (byte_value >= lo) && (byte_value <= hi);
  assign byte_off = byte_value - lo;

  assign res_valid    = out_full;
  assign mapped_index = out_idx;
  assign status       = out_st;

  // Next state of the byte sequencer.
  always_comb begin
    st_next = st;
    case (st)
      BK_IDLE: begin
        if (q_valid) begin
          if (op != OP_MAP) st_next = BK_IDLE;
          else if (!in_seq) st_next = BK_BASE;
          else if (done) st_next = BK_EMIT;
          else st_next = BK_READ;
        end
      end
      BK_BASE:  st_next = done ? BK_EMIT : BK_READ;
      BK_READ:  st_next = (k >= cur_count) ? BK_EMIT : BK_CHECK;
      BK_CHECK: begin
        if (!hit) st_next = BK_READ;
        else if (rd_bounds[21:20] == ACT_BAD) st_next = BK_EMIT;
        else st_next = BK_MUL;
      end
      BK_MUL:   st_next = BK_SUM;
      BK_SUM:   st_next = BK_EMIT;
      BK_EMIT:  st_next = (!last_byte || !out_full) ? BK_IDLE : BK_EMIT;
      default:  st_next = BK_IDLE;
    endcase
  end

  // Queue pop: table ops retire at once, bytes when finished.
  always_comb begin
    q_take = 1'b0;
    case (st)
      BK_IDLE: q_take = q_valid && (op != OP_MAP);
      BK_EMIT: q_take = !last_byte || !out_full;
      default: q_take = 1'b0;
    endcase
  end

  // Table writes and registered memory reads.
  always_ff @(posedge clk) begin
    if (st == BK_IDLE && q_valid && op == OP_ENTRY && st_ok && slot_ok) begin
      bounds_mem[wr_idx] <= {action, nxt_state, range_high, range_low};
      offs_mem[wr_idx]   <= entry_value;
      mul_mem[wr_idx]    <= entry_mul;
    end
    if (st == BK_IDLE && q_valid && op == OP_BASE && st_ok) begin
      base_mem[SW'(table_state)] <= entry_value;
    end
    rd_bounds <= bounds_mem[rd_idx];
    rd_offs   <= offs_mem[rd_idx];
    rd_mul    <= mul_mem[rd_idx];
    rd_base   <= base_mem[start_sel];
    product   <= {24'd0, byte_off} * rd_mul;
  end

  // Control registers of the sequence.
  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= BK_IDLE;
      in_seq   <= 1'b0;
      done     <= 1'b0;
      pend     <= ST_OK;
      cur_state <= '0;
      sum      <= '0;
      k        <= '0;
      out_full <= 1'b0;
      for (int i = 0; i < NUM_STATES; i++) counts[i] <= '0;
    end else begin
      st <= st_next;
      if (out_full && res_take) out_full <= 1'b0;
      case (st)
        BK_IDLE: begin
          k <= '0;
          if (q_valid && op == OP_COUNT && st_ok) begin
            counts[SW'(table_state)] <= ({4'd0, slot} > 8'(ENTRIES_PER_STATE))
              ? CW'(ENTRIES_PER_STATE) : CW'(slot);
          end
          if (q_valid && op == OP_MAP && !in_seq) begin
            cur_state <= 4'(start_sel);
            in_seq <= 1'b1;
            done   <= 1'b0;
            pend   <= ST_OK;
          end
        end
        BK_BASE: sum <= rd_base;
        BK_READ: begin
          if (k >= cur_count) begin
            done <= 1'b1;
            pend <= ST_NO_MATCH;
          end
        end
        BK_CHECK: begin
          if (!hit) k <= k + 1'b1;
          else if (rd_bounds[21:20] == ACT_BAD) begin
            done <= 1'b1;
            pend <= ST_DISALLOWED;
          end
        end
        BK_SUM: begin
          sum <= sum + rd_offs + product;
          if (rd_bounds[21:20] == ACT_CONTINUE) cur_state <= rd_bounds[19:16];
          else begin
            done <= 1'b1;
            pend <= ST_OK;
          end
        end
        BK_EMIT: begin
          if (last_byte && !out_full) begin
            out_full <= 1'b1;
            out_st   <= done ? pend : ST_INCOMPLETE;
            out_idx  <= (done && pend == ST_OK) ? sum : 32'd0;
            in_seq   <= 1'b0;
            done     <= 1'b0;
            pend     <= ST_OK;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

[rtl/multibyte_sequence_indexer.sv]
// Top level of the multibyte sequence indexer.
// Usage: both sides look like queues. Push a transaction while full is low;
// op selects a table write (entry, state base, entry count) or a byte map.
// An accepted transaction is written into a four-deep input queue and
// reaches the back end from its head. Table writes retire at once in the
// back end idle state. A byte map tests the entries of the current state
// in slot order, each through a read and a check state, then passes the
// multiply, sum and emit states for the multiply-add and the result; the
// first byte of a sequence passes a base state first to load the state
// base. The back end thus searches the entries one at a time.
// A result appears only for the last byte of a sequence; it is held on
// mapped_index and status while empty is low and leaves on pop.
// The input queue decouples acceptance from the back end, so pushes
// continue while a result waits; when the receiver stalls, the back end
// holds the next last byte until the result register drains.
// Reset (rst, synchronous) clears entry counts, the sequence state and both
// queues; entry and base tables stay undefined until written.
module multibyte_sequence_indexer
  import msi_pkg::*;
#(
  parameter int NUM_STATES = 16,
  parameter int ENTRIES_PER_STATE = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  op,
  input  logic [3:0]  table_state,
  input  logic [3:0]  slot,
  input  logic [7:0]  range_low,
  input  logic [7:0]  range_high,
  input  logic [3:0]  nxt_state,
  input  logic [1:0]  action,
  input  logic [31:0] entry_value,
  input  logic [31:0] entry_mul,
  input  logic [7:0]  byte_value,
  input  logic        last_byte,
  input  logic        start_state_one,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] mapped_index,
  output logic [1:0]  status
);

  localparam int W = 106;

  logic         q_valid;
  logic         q_take;
  logic [W-1:0] q_data;
  logic         res_valid;

  msi_front #(.W(W), .DEPTH(4)) u_front (
    .clk, .rst, .push, .full,
    .din({op, table_state, slot, range_low, range_high, nxt_state, action,
          entry_value, entry_mul, byte_value, last_byte, start_state_one}),
    .q_valid, .q_take, .q_data
  );

  msi_back #(.NUM_STATES(NUM_STATES), .ENTRIES_PER_STATE(ENTRIES_PER_STATE)) u_back (
    .clk, .rst, .q_valid, .q_take,
    .op(q_data[105:104]), .table_state(q_data[103:100]), .slot(q_data[99:96]),
    .range_low(q_data[95:88]), .range_high(q_data[87:80]),
    .nxt_state(q_data[79:76]), .action(q_data[75:74]),
    .entry_value(q_data[73:42]), .entry_mul(q_data[41:10]),
    .byte_value(q_data[9:2]), .last_byte(q_data[1]),
    .start_state_one(q_data[0]),
    .res_valid, .res_take(pop), .mapped_index, .status
  );

  assign empty = !res_valid;

endmodule

[rtl/msi_checker.sv]
// Port-level checker for the multibyte sequence indexer, with its bind.
module msi_checker
  import msi_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [31:0] mapped_index,
  input logic [1:0]  status
);

  // Error results always carry a zero index.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    !empty && status != ST_OK |-> mapped_index == 32'd0)
    else $error("error result with nonzero index");

  // A waiting result holds until popped.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(mapped_index) && $stable(status))
    else $error("result changed while stalled");

  // After reset nothing is pending and the input side is open.
  a_reset: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("not clear after reset");

endmodule

bind multibyte_sequence_indexer msi_checker u_chk (
  .clk, .rst, .full, .empty, .pop, .mapped_index, .status
);

[tb/tb_multibyte_sequence_indexer.sv]
// Testbench for the multibyte sequence indexer: directed table plus random sequences.
`timescale 1ns / 1ps

module tb_multibyte_sequence_indexer;
  import msi_pkg::*;

  localparam int NSTATE = 16;
  localparam int NENTRY = 8;

  // One input transaction, with an optional typed-in expectation.
  typedef struct {
    op_t         op;
    logic [3:0]  ts;
    logic [3:0]  slot;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [3:0]  nx;
    act_t        act;
    logic [31:0] val;
    logic [31:0] mul;
    logic [7:0]  b;
    logic        last;
    logic        ss1;
    bit          fixed;
    logic [31:0] fix_index;
    status_t     fix_status;
  } item_t;

  typedef struct {
    logic [31:0] index;
    status_t     st;
  } index_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  op = '0;
  logic [3:0]  table_state = '0;
  logic [3:0]  slot = '0;
  logic [7:0]  range_low = '0;
  logic [7:0]  range_high = '0;
  logic [3:0]  nxt_state = '0;
  logic [1:0]  action = '0;
  logic [31:0] entry_value = '0;
  logic [31:0] entry_mul = '0;
  logic [7:0]  byte_value = '0;
  logic        last_byte = 1'b0;
  logic        start_state_one = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [31:0] mapped_index;
  logic [1:0]  status;

  multibyte_sequence_indexer dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .op(op),
    .table_state(table_state), .slot(slot), .range_low(range_low),
    .range_high(range_high), .nxt_state(nxt_state), .action(action),
    .entry_value(entry_value), .entry_mul(entry_mul), .byte_value(byte_value),
    .last_byte(last_byte), .start_state_one(start_state_one), .empty(empty),
    .pop(pop), .mapped_index(mapped_index), .status(status)
  );

  // Shadow copy of the block's tables and sequence state.
  logic [7:0]  sh_lo [NSTATE*NENTRY];
  logic [7:0]  sh_hi [NSTATE*NENTRY];
  logic [3:0]  sh_nx [NSTATE*NENTRY];
  act_t        sh_act [NSTATE*NENTRY];
  logic [31:0] sh_off [NSTATE*NENTRY];
  logic [31:0] sh_mul [NSTATE*NENTRY];
  logic [31:0] sh_base [NSTATE];
  logic [3:0]  sh_count [NSTATE];
  logic [3:0]  cur_state;
  logic [31:0] cur_sum;
  bit          seq_open;
  bit          seq_done;
  status_t     seq_status;

  index_result_t expected_indices[$];
  int errors = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

  // Apply one byte of a sequence to the shadow state.
  task automatic walk_byte(input logic [7:0] b);
    int cnt;
    int idx;
    cnt = sh_count[cur_state];
    for (int k = 0; k < cnt; k++) begin
      idx = cur_state * NENTRY + k;
      if (b >= sh_lo[idx] && b <= sh_hi[idx]) begin
        if (sh_act[idx] == ACT_BAD) begin
          seq_done = 1;
          seq_status = ST_DISALLOWED;
        end else begin
          cur_sum = cur_sum + sh_off[idx] + (32'(b - sh_lo[idx]) * sh_mul[idx]);
          if (sh_act[idx] == ACT_CONTINUE) begin
            cur_state = sh_nx[idx];
          end else begin
            seq_done = 1;
            seq_status = ST_OK;
          end
        end
        return;
      end
    end
    seq_done = 1;
    seq_status = ST_NO_MATCH;
  endtask

  // Update the shadow state for an accepted transaction and queue any result.
  task automatic predict_index(input item_t it);
    index_result_t r;
    int idx;
    case (it.op)
      OP_ENTRY: begin
        if (it.slot < NENTRY) begin
          idx = it.ts * NENTRY + it.slot;
          sh_lo[idx] = it.lo;
          sh_hi[idx] = it.hi;
          sh_nx[idx] = it.nx;
          sh_act[idx] = it.act;
          sh_off[idx] = it.val;
          sh_mul[idx] = it.mul;
        end
      end
      OP_BASE: sh_base[it.ts] = it.val;
      OP_COUNT: sh_count[it.ts] = (it.slot > NENTRY) ? 4'(NENTRY) : it.slot;
      default: begin
        if (!seq_open) begin
          cur_state = (it.ss1 && !it.last) ? 4'd1 : 4'd0;
          cur_sum = sh_base[cur_state];
          seq_open = 1;
          seq_done = 0;
          seq_status = ST_OK;
        end
        if (!seq_done) walk_byte(it.b);
        if (it.last) begin
          r.st = seq_done ? seq_status : ST_INCOMPLETE;
          r.index = (r.st == ST_OK) ? cur_sum : 32'd0;
          if (it.fixed) begin
            r.index = it.fix_index;
            r.st = it.fix_status;
          end
          expected_indices = {expected_indices, r};
          seq_open = 0;
          seq_done = 0;
        end
      end
    endcase
  endtask

  function automatic item_t mk(op_t o, int ts, int sl, int lo, int hi, int nx, act_t a,
                               logic [31:0] v, logic [31:0] m, int b, int last, int ss1,
                               int fixed = 0, status_t fst = ST_OK);
    item_t it;
    it.op = o; it.ts = 4'(ts); it.slot = 4'(sl); it.lo = 8'(lo); it.hi = 8'(hi);
    it.nx = 4'(nx); it.act = a; it.val = v; it.mul = m; it.b = 8'(b);
    it.last = 1'(last); it.ss1 = 1'(ss1);
    it.fixed = 1'(fixed); it.fix_index = 32'd0; it.fix_status = fst;
    return it;
  endfunction

  // Random table entry with mostly wide ranges so sequences get deep.
  function automatic item_t rand_entry(int ts, int sl);
    item_t it;
    int r;
    it = mk(OP_ENTRY, ts, sl, 0, 0, $urandom_range(0, 15), ACT_CONTINUE,
            $urandom, $urandom, $urandom_range(0, 255), $urandom_range(0, 1),
            $urandom_range(0, 1));
    r = $urandom_range(0, 9);
    it.act = (r < 4) ? ACT_CONTINUE : (r < 6) ? ACT_FINAL : (r < 9) ? ACT_FINAL_PAIR : ACT_BAD;
    if ($urandom_range(0, 9) == 0) begin
      it.lo = 8'($urandom_range(0, 255));
      it.hi = 8'($urandom_range(0, 255));
    end else begin
      it.lo = 8'($urandom_range(0, 120));
      it.hi = 8'($urandom_range(100, 255));
    end
    return it;
  endfunction

  function automatic item_t rand_noise(op_t o);
    return mk(o, $urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 255),
              $urandom_range(0, 255), $urandom_range(0, 15), act_t'($urandom_range(0, 3)),
              $urandom, $urandom, $urandom_range(0, 255), $urandom_range(0, 1),
              $urandom_range(0, 1));
  endfunction

  // Offer one transaction after a random gap and hold it until accepted.
  task automatic send_item(input item_t it);
    int gap;
    gap = $urandom_range(0, 9);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push <= 1'b1;
    op <= it.op; table_state <= it.ts; slot <= it.slot;
    range_low <= it.lo; range_high <= it.hi; nxt_state <= it.nx;
    action <= it.act; entry_value <= it.val; entry_mul <= it.mul;
    byte_value <= it.b; last_byte <= it.last; start_state_one <= it.ss1;
    do @(posedge clk); while (full);
    predict_index(it);
    @(negedge clk);
  endtask

  // Result side: random pop stalls, compare each popped result.
  initial begin
    int gap;
    index_result_t e;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = $urandom_range(0, 9);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      if (expected_indices.size() == 0) begin
        $error("unexpected result: mapped_index %h status %0d", mapped_index, status);
        errors++;
      end else begin
        e = expected_indices.pop_front();
        if (mapped_index !== e.index) begin
          $error("mapped_index expected %h actual %h", e.index, mapped_index);
          errors++;
        end
        if (status !== e.st) begin
          $error("status expected %0d actual %0d", e.st, status);
          errors++;
        end
      end
      @(negedge clk);
    end
  end

  // Stimulus: table fill, directed table, then random sequences.
  initial begin
    item_t directed[$];
    int sent;
    int n;
    for (int s = 0; s < NSTATE; s++) sh_count[s] = '0;
    seq_open = 0; seq_done = 0; seq_status = ST_OK; cur_state = '0; cur_sum = '0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Fill every base and entry so no unwritten location is ever read.
    for (int s = 0; s < NSTATE; s++) begin
      send_item(mk(OP_BASE, s, $urandom_range(0, 15), 0, 0, 0, ACT_CONTINUE, $urandom,
                   $urandom, 0, 0, 0));
      for (int k = 0; k < NENTRY; k++) send_item(rand_entry(s, k));
    end

    // Empty tables give no match.
    directed = {directed, mk(OP_MAP, 0, 0, 0, 0, 0, ACT_CONTINUE, 0, 0, 0, 1, 0, 1,
                             ST_NO_MATCH)};
    directed = {directed, mk(OP_BASE, 0, 0, 0, 0, 0, ACT_CONTINUE, 32'hFFFF_FFFF, 0,
                             0, 0, 0)};
    directed = {directed, mk(OP_BASE, 1, 0, 0, 0, 0, ACT_CONTINUE, 32'h0, 0, 0, 0, 0)};
    directed = {directed, mk(OP_ENTRY, 0, 0, 0, 255, 0, ACT_FINAL, 32'd1, 32'hFFFF_FFFF,
                             0, 0, 0)};
    // Count above the table size is clamped.
    directed = {directed, mk(OP_COUNT, 0, 15, 0, 0, 0, ACT_CONTINUE, 0, 0, 0, 0, 0)};
    directed = {directed, mk(OP_MAP, 0, 0, 0, 0, 0, ACT_CONTINUE, 0, 0, 255, 1, 0)};
    // Disallowed action.
    directed = {directed, mk(OP_ENTRY, 0, 0, 0, 255, 0, ACT_BAD, 0, 0, 0, 0, 0)};
    directed = {directed, mk(OP_MAP, 0, 0, 0, 0, 0, ACT_CONTINUE, 0, 0, 0, 1, 0, 1,
                             ST_DISALLOWED)};
    // Out-of-range slot write is dropped.
    directed = {directed, mk(OP_ENTRY, 0, 8, 0, 255, 3, ACT_FINAL, 32'h1234, 7,
                             0, 0, 0)};
    // Reversed range matches nothing.
    directed = {directed, mk(OP_ENTRY, 0, 0, 200, 100, 0, ACT_FINAL, 0, 0, 0, 0, 0)};
    directed = {directed, mk(OP_MAP, 0, 0, 0, 0, 0, ACT_CONTINUE, 0, 0, 150, 1, 0)};
    // Sequence ends on a continue entry.
    directed = {directed, mk(OP_ENTRY, 0, 0, 0, 255, 15, ACT_CONTINUE, 5, 1, 0, 0, 0)};
    directed = {directed, mk(OP_MAP, 0, 0, 0, 0, 0, ACT_CONTINUE, 0, 0, 7, 1, 0, 1,
                             ST_INCOMPLETE)};
    directed = {directed, mk(OP_ENTRY, 15, 0, 0, 255, 0, ACT_FINAL_PAIR, 5, 3,
                             0, 0, 0)};
    directed = {directed, mk(OP_COUNT, 15, 1, 0, 0, 0, ACT_CONTINUE, 0, 0, 0, 0, 0)};
    directed = {directed, mk(OP_MAP, 0, 0, 0, 0, 0, ACT_CONTINUE, 0, 0, 9, 0, 0)};
    // Table write in the middle of a sequence.
    directed = {directed, mk(OP_COUNT, 15, 0, 0, 0, 0, ACT_CONTINUE, 0, 0, 0, 0, 0)};
    directed = {directed, mk(OP_MAP, 0, 0, 0, 0, 0, ACT_CONTINUE, 0, 0, 4, 1, 0)};
    // Start in state one.
    directed = {directed, mk(OP_ENTRY, 1, 0, 0, 255, 15, ACT_CONTINUE, 0, 1, 0, 0, 0)};
    directed = {directed, mk(OP_COUNT, 1, 1, 0, 0, 0, ACT_CONTINUE, 0, 0, 0, 0, 0)};
    directed = {directed, mk(OP_COUNT, 15, 1, 0, 0, 0, ACT_CONTINUE, 0, 0, 0, 0, 0)};
    directed = {directed, mk(OP_MAP, 0, 0, 0, 0, 0, ACT_CONTINUE, 0, 0, 255, 0, 1)};
    directed = {directed, mk(OP_MAP, 0, 0, 0, 0, 0, ACT_CONTINUE, 0, 0, 0, 1, 1)};
    // A single last byte starts in state zero even with the flag set.
    directed = {directed, mk(OP_MAP, 0, 0, 0, 0, 0, ACT_CONTINUE, 0, 0, 255, 1, 1)};
    foreach (directed[i]) send_item(directed[i]);

    // Random part: mostly well-formed sequences, some table writes.
    sent = 0;
    while (sent < 1200) begin
      if ($urandom_range(0, 9) < 2) begin
        case ($urandom_range(0, 2))
          0: send_item(rand_entry($urandom_range(0, 15), $urandom_range(0, 15)));
          1: send_item(rand_noise(OP_BASE));
          default: send_item(rand_noise(OP_COUNT));
        endcase
        sent++;
      end else begin
        n = $urandom_range(1, 4);
        for (int j = 0; j < n; j++) begin
          item_t it;
          it = rand_noise(OP_MAP);
          it.last = (j == n - 1);
          send_item(it);
          sent++;
        end
      end
    end
    push <= 1'b0;

    // Drain remaining results, then let trailing writes settle.
    while (expected_indices.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/msi_pkg.sv
rtl/msi_front.sv
rtl/msi_back.sv
rtl/multibyte_sequence_indexer.sv
rtl/msi_checker.sv
tb/tb_multibyte_sequence_indexer.sv
